### hw/rtl/lscpu_pkg.sv
// Shared types and constants for the load/store CPU execute step.
// Holds the opcode and status codes, stream field layout and the data memory
// request struct. No dependencies.
package lscpu_pkg;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_ADDI    = 4'd2,
        OP_MUL     = 4'd3,
        OP_LW      = 4'd4,
        OP_SW      = 4'd5,
        OP_BEQ     = 4'd6,
        OP_BNE     = 4'd7,
        OP_J       = 4'd8,
        OP_JAL     = 4'd9,
        OP_JR      = 4'd10,
        OP_SYSCALL = 4'd11
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_HALT        = 3'd1,
        ST_LOAD_FAULT  = 3'd2,
        ST_STORE_FAULT = 3'd3,
        ST_BAD_OP      = 3'd4,
        ST_STOPPED     = 3'd5
    } status_t;

    // Fixed register roles.
    localparam logic [4:0] REG_LINK = 5'd31;
    localparam logic [4:0] REG_SEL  = 5'd2;
    localparam logic [4:0] REG_ARG  = 5'd4;

    // Service call selectors held in the selector register.
    localparam logic [31:0] SYS_PRINT = 32'd1;
    localparam logic [31:0] SYS_READ  = 32'd5;
    localparam logic [31:0] SYS_EXIT  = 32'd10;

    // Input tdata layout, lowest bit first.
    localparam int S_TDATA_W = 104;
    localparam int F_OPCODE  = 0;
    localparam int F_DEST    = 4;
    localparam int F_SRC_A   = 9;
    localparam int F_SRC_B   = 14;
    localparam int F_IMM     = 19;
    localparam int F_RDVAL   = 51;
    localparam int F_PADDR   = 83;
    localparam int F_PBYTE   = 95;

    // Output tdata width (106 bits of fields, padded to whole bytes).
    localparam int M_TDATA_W = 112;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic [3:0] wr_mask;  // byte lanes in word order, lane 0 at the address
    } dmem_req_t;

endpackage

### hw/rtl/lscpu_rf.sv
// Register file of the execute step: 32 x 32-bit synchronous memory with two
// registered read ports, write-through, valid bits and shadows of r2 and r4.
// Depends on lscpu_pkg.
module lscpu_rf
    import lscpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  addr_a,
    input  logic [4:0]  addr_b,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    output logic [31:0] data_a,
    output logic [31:0] data_b,
    output logic [31:0] sel_val,
    output logic [31:0] arg_val
);

    logic [31:0] rf_mem [32];
    logic [31:0] vld_reg;
    logic [31:0] q_a_reg;
    logic [31:0] q_b_reg;
    logic        qv_a_reg;
    logic        qv_b_reg;
    logic [31:0] sel_reg;
    logic [31:0] arg_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[waddr] <= wdata;
        end
    end

    // A write to the address being read, or held, lands in the read register,
    // so the held operand stays current while its consumer is stalled.
    always_ff @(posedge clk)
    begin
        if (we && waddr == addr_a)
        begin
            q_a_reg  <= wdata;
            qv_a_reg <= 1'b1;
        end
        else if (rd_en)
        begin
            q_a_reg  <= rf_mem[addr_a];
            qv_a_reg <= vld_reg[addr_a];
        end

        if (we && waddr == addr_b)
        begin
            q_b_reg  <= wdata;
            qv_b_reg <= 1'b1;
        end
        else if (rd_en)
        begin
            q_b_reg  <= rf_mem[addr_b];
            qv_b_reg <= vld_reg[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            sel_reg <= '0;
            arg_reg <= '0;
        end
        else if (we)
        begin
            vld_reg[waddr] <= 1'b1;
            if (waddr == REG_SEL)
            begin
                sel_reg <= wdata;
            end
            if (waddr == REG_ARG)
            begin
                arg_reg <= wdata;
            end
        end
    end

    assign data_a  = qv_a_reg ? q_a_reg : '0;
    assign data_b  = qv_b_reg ? q_b_reg : '0;
    assign sel_val = sel_reg;
    assign arg_val = arg_reg;

endmodule

### hw/rtl/lscpu_dmem.sv
// Byte-addressed little-endian data memory in four byte banks, so that one
// unaligned word is read or written in one access. Clears itself after
// reset, one row per cycle. Depends on lscpu_pkg.
module lscpu_dmem
    import lscpu_pkg::*;
#(
    parameter int MEM_BYTES = 4096,
    localparam int ROWS = (MEM_BYTES + 3) / 4,
    localparam int RW   = $clog2(ROWS),
    localparam int AW   = RW + 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  dmem_req_t     req,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata,
    output logic          busy
);

    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic          busy_reg;
    logic [RW-1:0] clr_row_reg;
    logic [1:0]    off_reg;
    logic [7:0]    bank_q [4];

    for (genvar j = 0; j < 4; j++)
    begin : gen_bank
        logic [7:0]    bank_mem [ROWS];
        logic [7:0]    q_reg;
        logic [1:0]    lane;
        logic          carry;
        logic [RW-1:0] row;
        logic          bank_we;
        logic [7:0]    bank_wd;

        // Bank j holds word lane (j - addr[1:0]); lanes that wrap sit one row up.
        assign lane    = 2'(j) - addr[1:0];
        assign carry   = 2'(j) < addr[1:0];
        assign row     = addr[AW-1:2] + {{(RW-1){1'b0}}, carry};
        assign bank_we = req.wr_en && req.wr_mask[lane];
        assign bank_wd = wdata[{lane, 3'b000} +: 8];

        always_ff @(posedge clk)
        begin
            if (busy_reg)
            begin
                bank_mem[clr_row_reg] <= '0;
            end
            else if (bank_we)
            begin
                bank_mem[row] <= bank_wd;
            end
            if (req.rd_en)
            begin
                q_reg <= bank_mem[row];
            end
        end

        assign bank_q[j] = q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            off_reg <= addr[1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rdata[8*i +: 8] = bank_q[2'(off_reg + 2'(i))];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_row_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_row_reg == LAST_ROW)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
        end
    end

    assign busy = busy_reg;

endmodule

### hw/rtl/load_store_cpu_execute_step.sv
// Load/store CPU execute step: one decoded instruction or one memory preload
// per input transaction, one result transaction each. Uses lscpu_pkg,
// lscpu_rf and lscpu_dmem.
//
// The block takes one transaction per clock while the output is not stalled and
// no load hazard holds it. The register file is read when a transaction is
// accepted, the instruction is evaluated and memory is addressed when it leaves
// the evaluate stage, and the write-back and the result register load when it
// leaves the write-back stage. An item that directly follows a load is held in
// the evaluate stage when the loaded register is named by its source fields or
// is register 2 or 4, until the load data reaches the register file. After
// reset, tready stays low while the data memory is cleared one four-byte row
// per cycle. Once a fault or halt is reported, every later transaction is
// answered with the stopped status.
module load_store_cpu_execute_step_unit
    import lscpu_pkg::*;
#(
    parameter int MEM_BYTES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode, dest_reg, src_reg_a, src_reg_b, immediate, read_value,
    // preload_address, preload_byte, one zero pad bit
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // next_pc, status, print_valid, print_value, reg_write_valid,
    // reg_write_index, reg_write_value, six zero pad bits
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ROWS = (MEM_BYTES + 3) / 4;
    localparam int AW   = $clog2(ROWS) + 2;
    localparam logic [31:0] ADDR_LAST = 32'(MEM_BYTES - 4);
    localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);

    // Architectural state outside the memories.
    logic [31:0] pc_reg;
    logic        stopped_reg;

    // Evaluate stage.
    logic        s1_v_reg;
    logic        s1_cmd_reg;
    logic [3:0]  s1_op_reg;
    logic [4:0]  s1_rd_reg;
    logic [4:0]  s1_rs_reg;
    logic [4:0]  s1_rt_reg;
    logic [31:0] s1_imm_reg;
    logic [31:0] s1_rdval_reg;
    logic [11:0] s1_paddr_reg;
    logic [7:0]  s1_pbyte_reg;

    // Write-back stage.
    logic        s2_v_reg;
    logic [31:0] s2_npc_reg;
    status_t     s2_status_reg;
    logic        s2_pv_reg;
    logic [31:0] s2_pval_reg;
    logic        s2_wv_reg;
    logic [4:0]  s2_widx_reg;
    logic [31:0] s2_wval_reg;
    logic        s2_load_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic accept;
    logic s1_adv;
    logic s2_adv;
    logic hazard;
    logic dmem_busy;

    logic [31:0] rf_a;
    logic [31:0] rf_b;
    logic [31:0] rf_sel;
    logic [31:0] rf_arg;
    logic [4:0]  rf_addr_a;
    logic [4:0]  rf_addr_b;
    logic        rf_we;
    logic [31:0] s2_wval_out;
    logic [31:0] dmem_rdata;

    logic        fwd_ok;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] sel_v;
    logic [31:0] arg_v;
    logic [31:0] eff_addr;
    logic        in_range;
    logic [31:0] product;
    logic [31:0] pc_plus1;

    status_t     x_status;
    logic [31:0] x_npc;
    logic        x_pv;
    logic [31:0] x_pval;
    logic        x_wv;
    logic [4:0]  x_widx;
    logic [31:0] x_wval;
    logic        x_load;
    logic        x_store;
    logic        x_preload;

    dmem_req_t   dmem_req;
    logic [31:0] dmem_addr;
    logic [31:0] dmem_wdata;

    // Handshake and stage advance.
    assign s2_adv   = s2_v_reg && (!m_tvalid_reg || m_tready);
    assign s1_adv   = s1_v_reg && !hazard && (!s2_v_reg || s2_adv);
    assign s_tready = !dmem_busy && (!s1_v_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    // Register file reads at accept; otherwise it watches the held sources.
    assign rf_addr_a   = accept ? s_tdata[F_SRC_A +: 5] : s1_rs_reg;
    assign rf_addr_b   = accept ? s_tdata[F_SRC_B +: 5] : s1_rt_reg;
    assign s2_wval_out = s2_load_reg ? dmem_rdata : s2_wval_reg;
    assign rf_we       = s2_adv && s2_wv_reg;

    lscpu_rf u_rf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .addr_a  (rf_addr_a),
        .addr_b  (rf_addr_b),
        .we      (rf_we),
        .waddr   (s2_widx_reg),
        .wdata   (s2_wval_out),
        .data_a  (rf_a),
        .data_b  (rf_b),
        .sel_val (rf_sel),
        .arg_val (rf_arg)
    );

    // The pending write-back is forwarded unless it is a load, whose data
    // arrives too late; that case holds the evaluate stage until it is written back.
    assign fwd_ok = s2_v_reg && s2_wv_reg && !s2_load_reg;
    assign op_a   = (fwd_ok && s2_widx_reg == s1_rs_reg) ? s2_wval_reg : rf_a;
    assign op_b   = (fwd_ok && s2_widx_reg == s1_rt_reg) ? s2_wval_reg : rf_b;
    assign sel_v  = (fwd_ok && s2_widx_reg == REG_SEL) ? s2_wval_reg : rf_sel;
    assign arg_v  = (fwd_ok && s2_widx_reg == REG_ARG) ? s2_wval_reg : rf_arg;
    assign hazard = s2_v_reg && s2_load_reg && s2_wv_reg &&
                    (s2_widx_reg == s1_rs_reg || s2_widx_reg == s1_rt_reg ||
                     s2_widx_reg == REG_SEL || s2_widx_reg == REG_ARG);

    assign eff_addr = op_a + s1_imm_reg;
    assign in_range = !eff_addr[31] && (eff_addr <= ADDR_LAST);
    assign product  = op_a * op_b;
    assign pc_plus1 = pc_reg + 32'd1;

    always_comb
    begin
        x_status  = ST_OK;
        x_npc     = pc_plus1;
        x_pv      = 1'b0;
        x_pval    = '0;
        x_wv      = 1'b0;
        x_widx    = '0;
        x_wval    = '0;
        x_load    = 1'b0;
        x_store   = 1'b0;
        x_preload = 1'b0;
        if (stopped_reg)
        begin
            x_status = ST_STOPPED;
        end
        else if (s1_cmd_reg)
        begin
            x_npc     = pc_reg;
            x_preload = {20'd0, s1_paddr_reg} < MEM_LIMIT;
        end
        else
        begin
            unique case (op_t'(s1_op_reg))
                OP_ADD:
                begin
                    x_wv   = 1'b1;
                    x_widx = s1_rd_reg;
                    x_wval = op_a + op_b;
                end
                OP_SUB:
                begin
                    x_wv   = 1'b1;
                    x_widx = s1_rd_reg;
                    x_wval = op_a - op_b;
                end
                OP_ADDI:
                begin
                    x_wv   = 1'b1;
                    x_widx = s1_rt_reg;
                    x_wval = eff_addr;
                end
                OP_MUL:
                begin
                    x_wv   = 1'b1;
                    x_widx = s1_rd_reg;
                    x_wval = product;
                end
                OP_LW:
                begin
                    if (!in_range)
                    begin
                        x_status = ST_LOAD_FAULT;
                    end
                    else
                    begin
                        x_wv   = 1'b1;
                        x_widx = s1_rt_reg;
                        x_load = 1'b1;
                    end
                end
                OP_SW:
                begin
                    if (!in_range)
                    begin
                        x_status = ST_STORE_FAULT;
                    end
                    else
                    begin
                        x_store = 1'b1;
                    end
                end
                OP_BEQ:
                begin
                    if (op_a == op_b)
                    begin
                        x_npc = s1_imm_reg;
                    end
                end
                OP_BNE:
                begin
                    if (op_a != op_b)
                    begin
                        x_npc = s1_imm_reg;
                    end
                end
                OP_J:
                begin
                    x_npc = s1_imm_reg;
                end
                OP_JAL:
                begin
                    x_wv   = 1'b1;
                    x_widx = REG_LINK;
                    x_wval = pc_plus1;
                    x_npc  = s1_imm_reg;
                end
                OP_JR:
                begin
                    x_npc = op_a;
                end
                OP_SYSCALL:
                begin
                    if (sel_v == SYS_PRINT)
                    begin
                        x_pv   = 1'b1;
                        x_pval = arg_v;
                    end
                    else if (sel_v == SYS_READ)
                    begin
                        x_wv   = 1'b1;
                        x_widx = REG_SEL;
                        x_wval = s1_rdval_reg;
                    end
                    else if (sel_v == SYS_EXIT)
                    begin
                        x_status = ST_HALT;
                    end
                end
                default:
                begin
                    x_status = ST_BAD_OP;
                end
            endcase
        end

        // Any non-ok outcome leaves the state alone and keeps the pc.
        if (x_status != ST_OK)
        begin
            x_npc   = pc_reg;
            x_wv    = 1'b0;
            x_widx  = '0;
            x_wval  = '0;
            x_load  = 1'b0;
            x_store = 1'b0;
        end
    end

    // Stores and preloads write at the evaluate edge; loads read there too.
    always_comb
    begin
        dmem_req.rd_en   = s1_adv && x_load;
        dmem_req.wr_en   = s1_adv && (x_store || x_preload);
        dmem_req.wr_mask = x_preload ? 4'b0001 : 4'b1111;
        dmem_addr        = x_preload ? {20'd0, s1_paddr_reg} : eff_addr;
        dmem_wdata       = x_preload ? {24'd0, s1_pbyte_reg} : op_b;
    end

    lscpu_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dmem_req),
        .addr  (dmem_addr[AW-1:0]),
        .wdata (dmem_wdata),
        .rdata (dmem_rdata),
        .busy  (dmem_busy)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            pc_reg       <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_v_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_v_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_v_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                pc_reg      <= x_npc;
                stopped_reg <= stopped_reg || (x_status != ST_OK);
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= s_tuser;
            s1_op_reg    <= s_tdata[F_OPCODE +: 4];
            s1_rd_reg    <= s_tdata[F_DEST +: 5];
            s1_rs_reg    <= s_tdata[F_SRC_A +: 5];
            s1_rt_reg    <= s_tdata[F_SRC_B +: 5];
            s1_imm_reg   <= s_tdata[F_IMM +: 32];
            s1_rdval_reg <= s_tdata[F_RDVAL +: 32];
            s1_paddr_reg <= s_tdata[F_PADDR +: 12];
            s1_pbyte_reg <= s_tdata[F_PBYTE +: 8];
        end

        if (s1_adv)
        begin
            s2_npc_reg    <= x_npc;
            s2_status_reg <= x_status;
            s2_pv_reg     <= x_pv;
            s2_pval_reg   <= x_pval;
            s2_wv_reg     <= x_wv;
            s2_widx_reg   <= x_widx;
            s2_wval_reg   <= x_wval;
            s2_load_reg   <= x_load;
        end

        if (s2_adv)
        begin
            m_tdata_reg <= {6'd0, s2_wval_out, s2_widx_reg, s2_wv_reg, s2_pval_reg,
                            s2_pv_reg, s2_status_reg, s2_npc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
